>>> rtl/fsh_pkg.sv
// ----------------------------------------------------------------------------
// fsh_pkg
// Constants, operation codes and the control/status types that the hash
// controller, datapath and top level share.
// ----------------------------------------------------------------------------
package fsh_pkg;

    // Hash constants.
    localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;
    localparam logic [63:0] PRIME_64  = 64'h00000100000001b3;
    localparam logic [63:0] GOLDEN    = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] SM_MUL1   = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] SM_MUL2   = 64'h94d049bb133111eb;
    localparam logic [63:0] ODD_MUL   = 64'hd6e8feb86659fd93;
    localparam logic [8:0]  BYTE_BIAS = 9'h09e;

    // Shift amounts.
    localparam int MIX_SHIFT = 17;
    localparam int SM_SHIFT1 = 30;
    localparam int SM_SHIFT2 = 27;
    localparam int SM_SHIFT3 = 31;

    // Accumulator start values.
    localparam logic [63:0] ACC_FNV_INIT   = FNV_BASIS ^ 64'hA;
    localparam logic [63:0] ACC_SHIFT_INIT = FNV_BASIS ^ 64'hB;
    localparam logic [63:0] ACC_GOLD_INIT  = FNV_BASIS ^ 64'hC;
    localparam logic [63:0] ACC_ODD_INIT   = FNV_BASIS ^ 64'hD;

    // Index of the final result word.
    localparam logic [1:0] LAST_WORD = 2'd3;

    // Operations run through the shared multiplier.
    typedef enum logic [2:0] {
        OP_ABS_FNV   = 3'd0,
        OP_ABS_SHIFT = 3'd1,
        OP_ABS_GOLD  = 3'd2,
        OP_ABS_ODD   = 3'd3,
        OP_MIX1      = 3'd4,
        OP_MIX2      = 3'd5
    } op_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load_in;
        logic       mul_start;
        logic       mul_wb;
        logic       seed_init;
        logic       clear_state;
        op_t        op;
        logic [1:0] word_idx;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic mul_done;
    } dp_status_t;

endpackage

>>> rtl/fsh_mul64.sv
// ----------------------------------------------------------------------------
// fsh_mul64
// Iterative 64 x 64 multiplier giving the low 64 bits of the product. It uses
// one 32 x 32 multiplier over its phases and pulses done when the result
// is ready.
// ----------------------------------------------------------------------------
module fsh_mul64 (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] op_a,
    input  logic [63:0] op_b,
    output logic        done,
    output logic [63:0] product
);

    logic        busy_reg;
    logic        busy_next;
    logic [1:0]  phase_reg;
    logic [1:0]  phase_next;
    logic        done_reg;
    logic        done_next;
    logic [63:0] a_reg;
    logic [63:0] b_reg;
    logic [63:0] prod_reg;
    logic [63:0] sum_reg;
    logic [31:0] mul_x;
    logic [31:0] mul_y;
    logic [63:0] mul_out;

    // Select the partial product for this phase: low by low, high by low,
    // then low by high. The high by high term falls outside 64 bits.
    always_comb
    begin
        case (phase_reg)
            2'd0:
            begin
                mul_x = a_reg[31:0];
                mul_y = b_reg[31:0];
            end
            2'd1:
            begin
                mul_x = a_reg[63:32];
                mul_y = b_reg[31:0];
            end
            default:
            begin
                mul_x = a_reg[31:0];
                mul_y = b_reg[63:32];
            end
        endcase
    end

    assign mul_out = {32'd0, mul_x} * {32'd0, mul_y};

    // Sequencing of the four phases.
    always_comb
    begin
        busy_next  = busy_reg;
        phase_next = phase_reg;
        done_next  = 1'b0;
        if (start)
        begin
            busy_next  = 1'b1;
            phase_next = 2'd0;
        end
        else if (busy_reg)
        begin
            phase_next = phase_reg + 2'd1;
            if (phase_reg == 2'd3)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            phase_reg <= 2'd0;
            done_reg  <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
    end

    // Operand capture, partial product register and running sum.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= op_a;
            b_reg <= op_b;
        end
        else if (busy_reg)
        begin
            prod_reg <= mul_out;
            case (phase_reg)
                2'd0:    sum_reg <= sum_reg;
                2'd1:    sum_reg <= prod_reg;
                default: sum_reg <= sum_reg + {prod_reg[31:0], 32'd0};
            endcase
        end
    end

    assign done    = done_reg;
    assign product = sum_reg;

endmodule

>>> rtl/fsh_datapath.sv
// ----------------------------------------------------------------------------
// fsh_datapath
// Accumulators, byte counter, seed and result registers of the hash, with
// the operand selection and write-back around the shared multiplier.
// ----------------------------------------------------------------------------
module fsh_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  fsh_pkg::ctrl_cmd_t cmd,
    output fsh_pkg::dp_status_t status,
    input  logic [7:0]         data_byte,
    output logic [63:0]        hash_word0,
    output logic [63:0]        hash_word1,
    output logic [63:0]        hash_word2,
    output logic [63:0]        hash_word3
);

    logic [63:0] acc_fnv_reg;
    logic [63:0] acc_fnv_next;
    logic [63:0] acc_shift_reg;
    logic [63:0] acc_shift_next;
    logic [63:0] acc_gold_reg;
    logic [63:0] acc_gold_next;
    logic [63:0] acc_odd_reg;
    logic [63:0] acc_odd_next;
    logic [63:0] count_reg;
    logic [63:0] count_next;
    logic [7:0]  byte_reg;
    logic [63:0] seed_reg;
    logic [63:0] z_reg;
    logic [63:0] word0_reg;
    logic [63:0] word1_reg;
    logic [63:0] word2_reg;
    logic [63:0] word3_reg;
    logic [63:0] byte_ext;
    logic [8:0]  byte_biased;
    logic [63:0] seed_step;
    logic [63:0] mul_a;
    logic [63:0] mul_b;
    logic        mul_done;
    logic [63:0] mul_p;
    logic [63:0] acc_sel;
    logic [63:0] word_value;

    assign byte_ext    = {56'd0, byte_reg};
    assign byte_biased = {1'b0, byte_reg} + fsh_pkg::BYTE_BIAS;
    assign seed_step   = seed_reg + fsh_pkg::GOLDEN;

    // Multiplier operands for each operation.
    always_comb
    begin
        case (cmd.op)
            fsh_pkg::OP_ABS_FNV:
            begin
                mul_a = acc_fnv_reg ^ byte_ext;
                mul_b = fsh_pkg::PRIME_64;
            end
            fsh_pkg::OP_ABS_SHIFT:
            begin
                mul_a = acc_shift_reg + (byte_ext << count_reg[2:0]);
                mul_b = fsh_pkg::PRIME_64;
            end
            fsh_pkg::OP_ABS_GOLD:
            begin
                mul_a = acc_gold_reg;
                mul_b = fsh_pkg::GOLDEN;
            end
            fsh_pkg::OP_ABS_ODD:
            begin
                mul_a = acc_odd_reg ^ {55'd0, byte_biased};
                mul_b = fsh_pkg::ODD_MUL;
            end
            fsh_pkg::OP_MIX1:
            begin
                mul_a = seed_step ^ (seed_step >> fsh_pkg::SM_SHIFT1);
                mul_b = fsh_pkg::SM_MUL1;
            end
            fsh_pkg::OP_MIX2:
            begin
                mul_a = z_reg ^ (z_reg >> fsh_pkg::SM_SHIFT2);
                mul_b = fsh_pkg::SM_MUL2;
            end
            default:
            begin
                mul_a = 64'd0;
                mul_b = 64'd0;
            end
        endcase
    end

    fsh_mul64 u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    assign status.mul_done = mul_done;

    // Accumulator paired with the result word being produced.
    always_comb
    begin
        case (cmd.word_idx)
            2'd0:    acc_sel = acc_fnv_reg;
            2'd1:    acc_sel = acc_shift_reg;
            2'd2:    acc_sel = acc_gold_reg;
            default: acc_sel = acc_odd_reg;
        endcase
    end

    assign word_value = mul_p ^ (mul_p >> fsh_pkg::SM_SHIFT3) ^ acc_sel;

    // Accumulator and counter updates. Clearing wins over write-back.
    always_comb
    begin
        acc_fnv_next   = acc_fnv_reg;
        acc_shift_next = acc_shift_reg;
        acc_gold_next  = acc_gold_reg;
        acc_odd_next   = acc_odd_reg;
        count_next     = count_reg;
        if (cmd.clear_state)
        begin
            acc_fnv_next   = fsh_pkg::ACC_FNV_INIT;
            acc_shift_next = fsh_pkg::ACC_SHIFT_INIT;
            acc_gold_next  = fsh_pkg::ACC_GOLD_INIT;
            acc_odd_next   = fsh_pkg::ACC_ODD_INIT;
            count_next     = 64'd0;
        end
        else if (cmd.mul_wb)
        begin
            case (cmd.op)
                fsh_pkg::OP_ABS_FNV:
                begin
                    acc_fnv_next = mul_p;
                end
                fsh_pkg::OP_ABS_SHIFT:
                begin
                    acc_shift_next = mul_p ^ (acc_fnv_reg >> fsh_pkg::MIX_SHIFT);
                end
                fsh_pkg::OP_ABS_GOLD:
                begin
                    acc_gold_next = mul_p ^ byte_ext ^ count_reg;
                end
                fsh_pkg::OP_ABS_ODD:
                begin
                    acc_odd_next = mul_p;
                    count_next   = count_reg + 64'd1;
                end
                default:
                begin
                    acc_fnv_next = acc_fnv_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_fnv_reg   <= fsh_pkg::ACC_FNV_INIT;
            acc_shift_reg <= fsh_pkg::ACC_SHIFT_INIT;
            acc_gold_reg  <= fsh_pkg::ACC_GOLD_INIT;
            acc_odd_reg   <= fsh_pkg::ACC_ODD_INIT;
            count_reg     <= 64'd0;
        end
        else
        begin
            acc_fnv_reg   <= acc_fnv_next;
            acc_shift_reg <= acc_shift_next;
            acc_gold_reg  <= acc_gold_next;
            acc_odd_reg   <= acc_odd_next;
            count_reg     <= count_next;
        end
    end

    // Input byte, seed, mixer scratch and result words.
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            byte_reg <= data_byte;
        end
        if (cmd.seed_init)
        begin
            seed_reg <= acc_fnv_reg ^ acc_shift_reg ^ acc_gold_reg ^ acc_odd_reg
                        ^ count_reg;
        end
        else if (cmd.mul_start && (cmd.op == fsh_pkg::OP_MIX1))
        begin
            seed_reg <= seed_step;
        end
        if (cmd.mul_wb && (cmd.op == fsh_pkg::OP_MIX1))
        begin
            z_reg <= mul_p;
        end
        if (cmd.mul_wb && (cmd.op == fsh_pkg::OP_MIX2))
        begin
            case (cmd.word_idx)
                2'd0:    word0_reg <= word_value;
                2'd1:    word1_reg <= word_value;
                2'd2:    word2_reg <= word_value;
                default: word3_reg <= word_value;
            endcase
        end
    end

    assign hash_word0 = word0_reg;
    assign hash_word1 = word1_reg;
    assign hash_word2 = word2_reg;
    assign hash_word3 = word3_reg;

endmodule

>>> rtl/fsh_ctrl.sv
// ----------------------------------------------------------------------------
// fsh_ctrl
// Controller of the hash: takes input transfers, steps the datapath through
// the absorb and finalisation multiplies and owns the result valid flag.
// ----------------------------------------------------------------------------
module fsh_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                is_last,
    input  logic                no_data,
    output logic                out_valid,
    input  logic                out_ready,
    output fsh_pkg::ctrl_cmd_t  cmd,
    input  fsh_pkg::dp_status_t status
);

    typedef enum logic [3:0] {
        ST_IDLE     = 4'b0001,
        ST_MUL_GO   = 4'b0010,
        ST_MUL_WAIT = 4'b0100,
        ST_FIN_WAIT = 4'b1000
    } state_t;

    state_t          state_reg;
    state_t          state_next;
    fsh_pkg::op_t    op_reg;
    fsh_pkg::op_t    op_next;
    logic [1:0]      idx_reg;
    logic [1:0]      idx_next;
    logic            last_reg;
    logic            last_next;
    logic            out_valid_reg;
    logic            out_valid_next;

    // Next state and command decode.
    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        idx_next        = idx_reg;
        last_next       = last_reg;
        out_valid_next  = out_valid_reg;
        in_ready        = 1'b0;
        cmd.load_in     = 1'b0;
        cmd.mul_start   = 1'b0;
        cmd.mul_wb      = 1'b0;
        cmd.seed_init   = 1'b0;
        cmd.clear_state = 1'b0;
        cmd.op          = op_reg;
        cmd.word_idx    = idx_reg;

        // The result leaves on its output transfer.
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    last_next   = is_last;
                    if (!no_data)
                    begin
                        op_next    = fsh_pkg::OP_ABS_FNV;
                        state_next = ST_MUL_GO;
                    end
                    else if (is_last)
                    begin
                        state_next = ST_FIN_WAIT;
                    end
                end
            end
            ST_MUL_GO:
            begin
                cmd.mul_start = 1'b1;
                state_next    = ST_MUL_WAIT;
            end
            ST_MUL_WAIT:
            begin
                if (status.mul_done)
                begin
                    cmd.mul_wb = 1'b1;
                    case (op_reg)
                        fsh_pkg::OP_ABS_FNV:
                        begin
                            op_next    = fsh_pkg::OP_ABS_SHIFT;
                            state_next = ST_MUL_GO;
                        end
                        fsh_pkg::OP_ABS_SHIFT:
                        begin
                            op_next    = fsh_pkg::OP_ABS_GOLD;
                            state_next = ST_MUL_GO;
                        end
                        fsh_pkg::OP_ABS_GOLD:
                        begin
                            op_next    = fsh_pkg::OP_ABS_ODD;
                            state_next = ST_MUL_GO;
                        end
                        fsh_pkg::OP_ABS_ODD:
                        begin
                            state_next = last_reg ? ST_FIN_WAIT : ST_IDLE;
                        end
                        fsh_pkg::OP_MIX1:
                        begin
                            op_next    = fsh_pkg::OP_MIX2;
                            state_next = ST_MUL_GO;
                        end
                        fsh_pkg::OP_MIX2:
                        begin
                            if (idx_reg == fsh_pkg::LAST_WORD)
                            begin
                                cmd.clear_state = 1'b1;
                                out_valid_next  = 1'b1;
                                state_next      = ST_IDLE;
                            end
                            else
                            begin
                                idx_next   = idx_reg + 2'd1;
                                op_next    = fsh_pkg::OP_MIX1;
                                state_next = ST_MUL_GO;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_FIN_WAIT:
            begin
                // The result registers are reused, so wait for the last
                // result to be taken.
                if (!out_valid_reg)
                begin
                    cmd.seed_init = 1'b1;
                    idx_next      = 2'd0;
                    op_next       = fsh_pkg::OP_MIX1;
                    state_next    = ST_MUL_GO;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= fsh_pkg::OP_ABS_FNV;
            idx_reg       <= 2'd0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            idx_reg       <= idx_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

>>> rtl/fnv_splitmix_256bit_hash_top.sv
// ----------------------------------------------------------------------------
// fnv_splitmix_256bit_hash_top
// Each byte takes four 64-bit multiplies, run one after another on the
// shared 32 x 32 multiplier. An item with no byte and no end mark starts no
// multiply. The end of a message adds eight mixer multiplies before the result.
// Reset clears the accumulators to their start values and the count to zero.
// ----------------------------------------------------------------------------
module fnv_splitmix_256bit_hash_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        is_last,
    input  logic        no_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] hash_word0,
    output logic [63:0] hash_word1,
    output logic [63:0] hash_word2,
    output logic [63:0] hash_word3
);

    fsh_pkg::ctrl_cmd_t  cmd;
    fsh_pkg::dp_status_t status;

    // Sequencing.
    fsh_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .is_last   (is_last),
        .no_data   (no_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .status    (status)
    );

    // Arithmetic and state.
    fsh_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .data_byte  (data_byte),
        .hash_word0 (hash_word0),
        .hash_word1 (hash_word1),
        .hash_word2 (hash_word2),
        .hash_word3 (hash_word3)
    );

endmodule
